// File: src/cprm_pkg.sv
// ----------------------------------------------------------------------------
// cprm_pkg
// Shared constants, command/status types and controller states for the
// chunk peak and rms level meter.
// ----------------------------------------------------------------------------
package cprm_pkg;

  localparam int SAMPLE_BITS              = 16;
  localparam int FS_SHIFT                 = SAMPLE_BITS - 1;
  localparam int SQ_SHIFT                 = 2 * (SAMPLE_BITS - 1);
  localparam int LEVEL_SCALE              = 10000;
  localparam int LEVEL_W                  = 14;
  localparam int INDEX_W                  = 32;
  localparam int FRAME_W                  = 17;
  // mean square quotient never exceeds 10^8, which fits in 27 bits
  localparam int MS_W                     = 27;
  localparam int ROOT_W                   = MS_W + 1;
  localparam int SCALE_DIGITS             = 8;
  localparam int ROOT_STEPS               = (MS_W + 1) / 2;
  localparam int DEFAULT_MAX_CHUNK_FRAMES = 65536;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_PREP,
    ST_SCALE,
    ST_DIVIDE,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accumulate;
    logic prep;
    logic scale_step;
    logic div_step;
    logic root_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close_chunk;
    logic out_free;
  } sts_t;

endpackage

// File: src/cprm_ctrl.sv
// ----------------------------------------------------------------------------
// cprm_ctrl
// Controller: accepts samples, then sequences the decimal scaling, the
// restoring division and the square root at each chunk end.
// ----------------------------------------------------------------------------
module cprm_ctrl #(
  parameter int MAX_CHUNK_FRAMES = cprm_pkg::DEFAULT_MAX_CHUNK_FRAMES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cprm_pkg::sts_t sts,
  output cprm_pkg::cmd_t cmd
);
  import cprm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNK_FRAMES + 1);
  localparam int T_W    = CNT_W + MS_W;
  localparam int STEP_W = $clog2(T_W);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_SCALE:  step_last = (step == STEP_W'(SCALE_DIGITS - 1));
      ST_DIVIDE: step_last = (step == STEP_W'(T_W - 1));
      ST_ROOT:   step_last = (step == STEP_W'(ROOT_STEPS - 1));
      default:   step_last = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = '0;
    unique case (state)
      ST_ACC: begin
        if (in_valid && sts.close_chunk) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (step_last) state_next = ST_DIVIDE;
        else step_next = step + STEP_W'(1);
      end
      ST_DIVIDE: begin
        if (step_last) state_next = ST_ROOT;
        else step_next = step + STEP_W'(1);
      end
      ST_ROOT: begin
        if (step_last) state_next = ST_EMIT;
        else step_next = step + STEP_W'(1);
      end
      ST_EMIT: begin
        if (sts.out_free) state_next = ST_ACC;
      end
      default: state_next = ST_ACC;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_ACC: begin
        in_ready       = 1'b1;
        cmd.accumulate = in_valid;
      end
      ST_PREP:   cmd.prep       = 1'b1;
      ST_SCALE:  cmd.scale_step = 1'b1;
      ST_DIVIDE: cmd.div_step   = 1'b1;
      ST_ROOT:   cmd.root_step  = 1'b1;
      ST_EMIT:   cmd.emit       = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/cprm_dp.sv
// ----------------------------------------------------------------------------
// cprm_dp
// Datapath: chunk accumulators, digit-serial decimal scaling, restoring
// divider, bit-pair square root and the output register.
// ----------------------------------------------------------------------------
module cprm_dp #(
  parameter int MAX_CHUNK_FRAMES = cprm_pkg::DEFAULT_MAX_CHUNK_FRAMES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [cprm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  last_sample,
  input  cprm_pkg::cmd_t                        cmd,
  output cprm_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cprm_pkg::INDEX_W-1:0]          chunk_index,
  output logic [cprm_pkg::LEVEL_W-1:0]          peak_level,
  output logic [cprm_pkg::LEVEL_W-1:0]          rms_level,
  output logic [cprm_pkg::FRAME_W-1:0]          frame_count
);
  import cprm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNK_FRAMES + 1);
  localparam int SUM_W  = SQ_SHIFT + CNT_W;
  localparam int T_W    = CNT_W + MS_W;
  localparam int FRAC_W = SQ_SHIFT + 4;
  localparam int PROD_W = SAMPLE_BITS + LEVEL_W;

  logic [SAMPLE_BITS-1:0] peak_magnitude;
  logic [SUM_W-1:0]       square_sum;
  logic [CNT_W-1:0]       samples_in_chunk;
  logic [INDEX_W-1:0]     chunk_counter;

  // quo holds the scaled sum, then the quotient, then the root remainder
  logic [T_W-1:0]         quo;
  logic [SQ_SHIFT-1:0]    frac;
  logic [CNT_W-1:0]       rem;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_W-1:0]      root_bit;

  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [FRAC_W-1:0]        frac_ext;
  logic [FRAC_W-1:0]        frac10;
  logic [T_W-1:0]           quo10;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           n_ext;
  logic                     q_bit;
  logic [CNT_W:0]           rem_diff;
  logic [ROOT_W-1:0]        ms;
  logic [ROOT_W-1:0]        trial;
  logic                     fits;
  logic [PROD_W-1:0]        peak_prod;

  // magnitude: the most negative sample maps to full scale
  assign raw = sample;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  assign sq  = mag * mag;

  // one decimal digit of square_sum * 10^8 / 2^SQ_SHIFT per step
  assign frac_ext = FRAC_W'(frac);
  assign frac10   = (frac_ext << 3) + (frac_ext << 1);
  assign quo10    = (quo << 3) + (quo << 1) + T_W'(frac10[FRAC_W-1:SQ_SHIFT]);

  assign rem_sh   = {rem, quo[T_W-1]};
  assign n_ext    = {1'b0, samples_in_chunk};
  assign q_bit    = (rem_sh >= n_ext);
  assign rem_diff = rem_sh - n_ext;

  assign ms    = ROOT_W'(quo[MS_W-1:0]);
  assign trial = root + root_bit;
  assign fits  = (ms >= trial);

  assign peak_prod = peak_magnitude * LEVEL_W'(LEVEL_SCALE);

  assign sts.close_chunk = last_sample ||
                           (samples_in_chunk == CNT_W'(MAX_CHUNK_FRAMES - 1));
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_magnitude   <= '0;
      square_sum       <= '0;
      samples_in_chunk <= '0;
      chunk_counter    <= '0;
    end else if (cmd.accumulate) begin
      if (mag > peak_magnitude) peak_magnitude <= mag;
      square_sum       <= square_sum + SUM_W'(sq);
      samples_in_chunk <= samples_in_chunk + CNT_W'(1);
    end else if (cmd.emit) begin
      peak_magnitude   <= '0;
      square_sum       <= '0;
      samples_in_chunk <= '0;
      chunk_counter    <= chunk_counter + INDEX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo      <= T_W'(square_sum >> SQ_SHIFT);
      frac     <= square_sum[SQ_SHIFT-1:0];
      rem      <= '0;
      root     <= '0;
      root_bit <= ROOT_W'(1) << (MS_W - 1);
    end else if (cmd.scale_step) begin
      quo  <= quo10;
      frac <= frac10[SQ_SHIFT-1:0];
    end else if (cmd.div_step) begin
      quo <= {quo[T_W-2:0], q_bit};
      rem <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end else if (cmd.root_step) begin
      if (fits) begin
        quo  <= {quo[T_W-1:MS_W], MS_W'(ms - trial)};
        root <= (root >> 1) + root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chunk_index <= chunk_counter;
      peak_level  <= peak_prod[FS_SHIFT +: LEVEL_W];
      rms_level   <= root[LEVEL_W-1:0];
      frame_count <= FRAME_W'(samples_in_chunk);
    end
  end

endmodule

// File: src/chunk_peak_rms_meter.sv
// ----------------------------------------------------------------------------
// chunk_peak_rms_meter
// Peak and rms level meter over chunks of signed audio samples.
//
//   channel | signals                                 | role
//   --------+-----------------------------------------+-----------------------
//   in      | in_valid in_ready sample last_sample    | one sample per item
//   out     | out_valid out_ready chunk_index         | one result per chunk
//           | peak_level rms_level frame_count        |
//
// Samples that do not close their chunk are taken while in_ready stays high.
// A closing sample is followed, with in_ready low, by one prep step, 8
// decimal digit steps, CNT_W + 27 divider steps, 14 root steps and one load
// of the output register. The load waits while the previous result is still
// held; new samples are taken while a result waits.
// Reset clears the accumulators, the chunk counter and out_valid; in_ready
// is high from the first cycle.
// ----------------------------------------------------------------------------
module chunk_peak_rms_meter #(
  parameter int MAX_CHUNK_FRAMES = cprm_pkg::DEFAULT_MAX_CHUNK_FRAMES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cprm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  last_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cprm_pkg::INDEX_W-1:0]          chunk_index,
  output logic [cprm_pkg::LEVEL_W-1:0]          peak_level,
  output logic [cprm_pkg::LEVEL_W-1:0]          rms_level,
  output logic [cprm_pkg::FRAME_W-1:0]          frame_count
);
  import cprm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cprm_ctrl #(
    .MAX_CHUNK_FRAMES(MAX_CHUNK_FRAMES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cprm_dp #(
    .MAX_CHUNK_FRAMES(MAX_CHUNK_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .last_sample (last_sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chunk_index (chunk_index),
    .peak_level  (peak_level),
    .rms_level   (rms_level),
    .frame_count (frame_count)
  );

`ifndef NO_ASSERTIONS
  // a flagged item closes the chunk, so input stalls for the computation
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_sample) |=> !in_ready)
    else $error("input not stalled after chunk end");

  // a result is never loaded over one that is still held
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_level <= LEVEL_W'(LEVEL_SCALE) &&
                   rms_level <= LEVEL_W'(LEVEL_SCALE)))
    else $error("level out of range");

  // accumulation and result load never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.accumulate |-> !cmd.emit)
    else $error("accumulate during emit");
`endif

endmodule
